>>> src/psp_pkg.sv
// Shared types, codes and the per-character parse step of the port-list parser.
// No dependencies; imported by psp_parser, port_list_spec_parser and the testbench.
package psp_pkg;

    localparam int PORT_SPACE_DEF  = 65536;
    localparam int PROTO_SPACE_DEF = 256;

    localparam logic [3:0] DEF_TYPE_MASK   = 4'd1;
    localparam logic       DEF_ALLOW       = 1'b1;

    localparam logic [0:0] CFG_DEFAULT_MASK = 1'b0;
    localparam logic [0:0] CFG_ALLOW_CHANGE = 1'b1;

    localparam logic [1:0] OP_PARSE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] KIND_RANGE = 2'd0;
    localparam logic [1:0] KIND_ERROR = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_PREFIX    = 3'd1;
    localparam logic [2:0] ERR_RANGE     = 3'd2;
    localparam logic [2:0] ERR_SYNTAX    = 3'd3;
    localparam logic [2:0] ERR_BACKWARDS = 3'd4;
    localparam logic [2:0] ERR_BRACKET   = 3'd5;
    localparam logic [2:0] ERR_NAME      = 3'd6;

    localparam logic [7:0] CH_DASH   = 8'd45;
    localparam logic [7:0] CH_COMMA  = 8'd44;
    localparam logic [7:0] CH_COLON  = 8'd58;
    localparam logic [7:0] CH_LBRACK = 8'd91;
    localparam logic [7:0] CH_RBRACK = 8'd93;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_QMARK  = 8'd63;
    localparam logic [7:0] CH_T      = 8'd84;
    localparam logic [7:0] CH_U      = 8'd85;
    localparam logic [7:0] CH_S      = 8'd83;
    localparam logic [7:0] CH_P      = 8'd80;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_SPACES  = 8'b0000_0010,
        PH_PENDING = 8'b0000_0100,
        PH_NUM1    = 8'b0000_1000,
        PH_AFTER1  = 8'b0001_0000,
        PH_DASH    = 8'b0010_0000,
        PH_NUM2    = 8'b0100_0000,
        PH_TAIL    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  pending;
        logic [16:0] start;
        logic [16:0] accum;
        logic [3:0]  mask;
        logic        err;
    } ps_t;

    // What one character asks of the datapath: at most one range, then
    // at most one event (error code, or end when the code is none).
    typedef struct packed {
        logic        rng_v;
        logic [15:0] rng_first;
        logic [15:0] rng_last;
        logic [3:0]  rng_mask;
        logic        ev_v;
        logic [2:0]  ev_code;
        logic [3:0]  ev_mask;
    } plan_t;

    typedef struct packed {
        ps_t   ps;
        plan_t plan;
    } work_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic [16:0] limit_of(input logic [3:0] mask,
                                             input logic [16:0] port_sz,
                                             input logic [16:0] proto_sz);
        return mask[3] ? (proto_sz - 17'd1) : (port_sz - 17'd1);
    endfunction

    function automatic logic [16:0] accumulate(input logic [16:0] accum,
                                               input logic [7:0] c,
                                               input logic [16:0] port_sz);
        logic [20:0] v;
        v = {4'd0, accum} * 21'd10 + {13'd0, c - CH_ZERO};
        return (v > {4'd0, port_sz}) ? port_sz : v[16:0];
    endfunction

    function automatic work_t do_fail(input work_t w, input logic [2:0] code);
        work_t r;
        r = w;
        if (!r.ps.err) begin
            r.plan.ev_v    = 1'b1;
            r.plan.ev_code = code;
            r.plan.ev_mask = r.ps.mask;
            r.ps.err       = 1'b1;
        end
        return r;
    endfunction

    function automatic work_t do_add(input work_t w, input logic [16:0] a,
                                     input logic [16:0] b);
        work_t r;
        r = w;
        r.plan.rng_v     = 1'b1;
        r.plan.rng_first = a[15:0];
        r.plan.rng_last  = b[15:0];
        r.plan.rng_mask  = r.ps.mask;
        return r;
    endfunction

    function automatic work_t begin_token(input work_t w, input logic [7:0] c);
        work_t r;
        r = w;
        if (c == CH_DASH) begin
            r.ps.start = r.ps.mask[3] ? 17'd0 : 17'd1;
            r.ps.phase = PH_DASH;
        end else if (is_digit(c)) begin
            r.ps.accum = {9'd0, c - CH_ZERO};
            r.ps.phase = PH_NUM1;
        end else if (c == CH_LBRACK || c == CH_RBRACK) begin
            r = do_fail(r, ERR_BRACKET);
        end else if ((c >= 8'd97 && c <= 8'd122) || c == CH_STAR || c == CH_QMARK) begin
            r = do_fail(r, ERR_NAME);
        end else begin
            r = do_fail(r, ERR_SYNTAX);
        end
        return r;
    endfunction

    function automatic work_t do_tail(input work_t w, input logic [7:0] c);
        work_t r;
        r = w;
        if (is_space(c)) begin
            r = w;
        end else if (c == CH_COMMA) begin
            r.ps.phase = PH_START;
        end else begin
            r = do_fail(r, (c == CH_RBRACK) ? ERR_BRACKET : ERR_SYNTAX);
        end
        return r;
    endfunction

    function automatic work_t do_after1(input work_t w, input logic [7:0] c);
        work_t r;
        r = w;
        if (is_space(c)) begin
            r = w;
        end else if (c == CH_DASH) begin
            r.ps.phase = PH_DASH;
        end else if (c == CH_COMMA) begin
            r = do_add(r, r.ps.start, r.ps.start);
            r.ps.phase = PH_START;
        end else if (c == CH_RBRACK) begin
            r = do_add(r, r.ps.start, r.ps.start);
            r = do_fail(r, ERR_BRACKET);
        end else begin
            r = do_fail(r, ERR_SYNTAX);
        end
        return r;
    endfunction

    function automatic work_t do_feed(input work_t w, input logic [7:0] c,
                                      input logic allow, input logic [16:0] port_sz,
                                      input logic [16:0] proto_sz);
        work_t       r;
        logic [16:0] lim;
        r   = w;
        lim = limit_of(w.ps.mask, port_sz, proto_sz);
        unique case (w.ps.phase)
            PH_START, PH_SPACES: begin
                if (is_space(c)) begin
                    r.ps.phase = PH_SPACES;
                end else if (allow) begin
                    r.ps.pending = c;
                    r.ps.phase   = PH_PENDING;
                end else begin
                    r = begin_token(r, c);
                end
            end
            PH_NUM1: begin
                if (is_digit(c)) begin
                    r.ps.accum = accumulate(r.ps.accum, c, port_sz);
                end else if (r.ps.accum > lim) begin
                    r = do_fail(r, ERR_RANGE);
                end else begin
                    r.ps.start = r.ps.accum;
                    r.ps.phase = PH_AFTER1;
                    r = do_after1(r, c);
                end
            end
            PH_AFTER1: r = do_after1(r, c);
            PH_DASH: begin
                if (is_digit(c)) begin
                    r.ps.accum = {9'd0, c - CH_ZERO};
                    r.ps.phase = PH_NUM2;
                end else if (c == CH_COMMA) begin
                    r = do_add(r, r.ps.start, lim);
                    r.ps.phase = PH_START;
                end else if (c == CH_RBRACK) begin
                    r = do_add(r, r.ps.start, lim);
                    r = do_fail(r, ERR_BRACKET);
                end else begin
                    r = do_fail(r, ERR_SYNTAX);
                end
            end
            PH_NUM2: begin
                if (is_digit(c)) begin
                    r.ps.accum = accumulate(r.ps.accum, c, port_sz);
                end else if (r.ps.accum > lim) begin
                    r = do_fail(r, ERR_RANGE);
                end else if (r.ps.accum < r.ps.start) begin
                    r = do_fail(r, ERR_BACKWARDS);
                end else begin
                    r = do_add(r, r.ps.start, r.ps.accum);
                    r.ps.phase = PH_TAIL;
                    r = do_tail(r, c);
                end
            end
            default: r = do_tail(r, c);
        endcase
        return r;
    endfunction

    function automatic work_t do_finish(input work_t w, input logic [16:0] port_sz,
                                        input logic [16:0] proto_sz);
        work_t       r;
        logic [16:0] lim;
        r   = w;
        lim = limit_of(w.ps.mask, port_sz, proto_sz);
        unique case (w.ps.phase)
            PH_SPACES: r = do_fail(r, ERR_SYNTAX);
            PH_NUM1: begin
                if (r.ps.accum > lim) r = do_fail(r, ERR_RANGE);
                else r = do_add(r, r.ps.accum, r.ps.accum);
            end
            PH_AFTER1: r = do_add(r, r.ps.start, r.ps.start);
            PH_DASH:   r = do_add(r, r.ps.start, lim);
            PH_NUM2: begin
                if (r.ps.accum > lim) r = do_fail(r, ERR_RANGE);
                else if (r.ps.accum < r.ps.start) r = do_fail(r, ERR_BACKWARDS);
                else r = do_add(r, r.ps.start, r.ps.accum);
            end
            default: r = w;
        endcase
        return r;
    endfunction

    function automatic work_t parse_step(input ps_t ps, input logic [7:0] c,
                                         input logic last, input logic allow,
                                         input logic [3:0] def_mask,
                                         input logic [16:0] port_sz,
                                         input logic [16:0] proto_sz);
        work_t w;
        w      = '0;
        w.ps   = ps;
        if (ps.err) begin
            if (last) begin
                w.plan.ev_v    = 1'b1;
                w.plan.ev_code = ERR_NONE;
                w.plan.ev_mask = ps.mask;
            end
        end else begin
            if (ps.phase == PH_PENDING) begin
                w.ps.phase = PH_START;
                if (c == CH_COLON) begin
                    if (ps.pending == CH_T)      w.ps.mask = 4'd1;
                    else if (ps.pending == CH_U) w.ps.mask = 4'd2;
                    else if (ps.pending == CH_S) w.ps.mask = 4'd4;
                    else if (ps.pending == CH_P) w.ps.mask = 4'd8;
                    else w = do_fail(w, ERR_PREFIX);
                end else begin
                    w = begin_token(w, ps.pending);
                    if (!w.ps.err) w = do_feed(w, c, allow, port_sz, proto_sz);
                end
            end else begin
                w = do_feed(w, c, allow, port_sz, proto_sz);
            end
            if (last && !w.ps.err) begin
                if (w.ps.phase == PH_PENDING) begin
                    w.ps.phase = PH_START;
                    w = begin_token(w, w.ps.pending);
                end
                if (!w.ps.err) w = do_finish(w, port_sz, proto_sz);
                if (!w.ps.err) begin
                    w.plan.ev_v    = 1'b1;
                    w.plan.ev_code = ERR_NONE;
                    w.plan.ev_mask = w.ps.mask;
                end
            end
        end
        if (last) begin
            w.ps.phase   = PH_START;
            w.ps.pending = 8'd0;
            w.ps.start   = 17'd0;
            w.ps.accum   = 17'd0;
            w.ps.mask    = def_mask;
            w.ps.err     = 1'b0;
        end
        return w;
    endfunction

endpackage

>>> src/psp_parser.sv
// Character parser: holds the token state and turns one character into a plan.
// Depends on psp_pkg (state types and the parse step).
module psp_parser
    import psp_pkg::*;
#(
    parameter int PORT_SPACE  = PORT_SPACE_DEF,
    parameter int PROTO_SPACE = PROTO_SPACE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] char_code,
    input  logic       is_last,
    input  logic       allow,
    input  logic [3:0] def_mask,
    input  logic       mask_load,
    input  logic [3:0] mask_data,
    output plan_t      plan,
    output logic [3:0] cur_mask
);

    localparam logic [16:0] PORT_SZ  = 17'(PORT_SPACE);
    localparam logic [16:0] PROTO_SZ = 17'(PROTO_SPACE);

    ps_t   ps_reg;
    work_t work;

    assign work     = parse_step(ps_reg, char_code, is_last, allow, def_mask,
                                 PORT_SZ, PROTO_SZ);
    assign plan     = work.plan;
    assign cur_mask = ps_reg.mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg.phase   <= PH_START;
            ps_reg.pending <= 8'd0;
            ps_reg.start   <= 17'd0;
            ps_reg.accum   <= 17'd0;
            ps_reg.mask    <= DEF_TYPE_MASK;
            ps_reg.err     <= 1'b0;
        end
        else if (step_en)
        begin
            ps_reg <= work.ps;
        end
        else if (mask_load)
        begin
            ps_reg.mask <= mask_data;
        end
    end

endmodule

>>> src/port_list_spec_parser.sv
// Top level of the port-list parser: table memory, range marker, counters, result queue.
// Depends on psp_pkg and psp_parser.
//
// Feed a port-list text one character per request (opcode parse), ending with is_last.
// A character that completes no range is taken in idle and, when it raises an error or the
// end result, passes through the event state. A completed range is marked into the protocol
// table entry by entry (read, then modify-write) through the memory's read and write ports,
// holding the input until the walk ends. A table read passes through the read state. After
// reset, and after each clear request, a clearing pass writes zero to every one of the
// PORT_SPACE entries, one per cycle; input stays stalled for the pass while configuration
// writes are still taken. Up to four results wait in an output queue; a new request is taken
// while the sequencer is idle and two or fewer results are waiting.
module port_list_spec_parser
    import psp_pkg::*;
#(
    parameter int PORT_SPACE  = PORT_SPACE_DEF,
    parameter int PROTO_SPACE = PROTO_SPACE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    input  logic [15:0] entry_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [15:0] range_first,
    output logic [15:0] range_final,
    output logic [3:0]  type_mask,
    output logic        duplicate_seen,
    output logic [2:0]  error_code,
    output logic [3:0]  entry_bits,
    output logic [16:0] tcp_total,
    output logic [16:0] udp_total,
    output logic [16:0] sctp_total,
    output logic [8:0]  proto_total,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int AW = $clog2(PORT_SPACE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PORT_SPACE - 1);
    localparam logic [16:0]   PORT_SZ   = 17'(PORT_SPACE);
    localparam logic [16:0]   PROTO_SZ  = 17'(PROTO_SPACE);

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b00_0001,
        S_IDLE    = 6'b00_0010,
        S_READ    = 6'b00_0100,
        S_MARK_RD = 6'b00_1000,
        S_MARK_WR = 6'b01_0000,
        S_EVENT   = 6'b10_0000
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] first;
        logic [15:0] final_no;
        logic [3:0]  mask;
        logic        dup;
        logic [2:0]  err;
        logic [3:0]  bits;
        logic [16:0] tcp;
        logic [16:0] udp;
        logic [16:0] sctp;
        logic [8:0]  proto;
    } res_t;

    state_t      state_reg, state_next;
    logic [AW-1:0] clr_ptr_reg;
    logic [15:0] mark_ptr_reg;
    plan_t       plan_reg;
    plan_t       plan;
    logic        rng_dup_reg;
    logic        dup_warned_reg;
    logic        rd_oor_reg;
    logic [3:0]  def_mask_reg;
    logic        allow_reg;
    logic [3:0]  cur_mask;

    logic [16:0] tcp_reg, udp_reg, sctp_reg;
    logic [8:0]  proto_reg;
    logic [16:0] tcp_next, udp_next, sctp_next;
    logic [8:0]  proto_next;

    // Table memory: one write and one registered read per cycle
    logic [3:0]    port_mem [PORT_SPACE];
    logic [3:0]    rd_data_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [3:0]    wr_data;
    logic          wr_en;

    // Result queue
    res_t        res_q_reg [4];
    logic [1:0]  head_reg, tail_reg;
    logic [2:0]  count_reg;
    logic        push, pop;
    res_t        push_data;

    logic accept, mask_load, hit, mark_done, in_proto;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = !((state_reg == S_IDLE) && (count_reg <= 3'd2));
    assign mask_load = cfg_we && (cfg_index == CFG_DEFAULT_MASK);

    psp_parser #(
        .PORT_SPACE  (PORT_SPACE),
        .PROTO_SPACE (PROTO_SPACE)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (accept && (opcode == OP_PARSE)),
        .char_code (char_code),
        .is_last   (is_last),
        .allow     (allow_reg),
        .def_mask  (def_mask_reg),
        .mask_load (mask_load),
        .mask_data (cfg_data),
        .plan      (plan),
        .cur_mask  (cur_mask)
    );

    // Marking: an entry already carrying any of the mask bits is a duplicate
    assign hit       = |(rd_data_reg & plan_reg.rng_mask);
    assign mark_done = (mark_ptr_reg == plan_reg.rng_last);
    assign in_proto  = ({1'b0, mark_ptr_reg} < PROTO_SZ);

    always_comb
    begin
        tcp_next   = tcp_reg;
        udp_next   = udp_reg;
        sctp_next  = sctp_reg;
        proto_next = proto_reg;
        if (state_reg == S_MARK_WR && !hit)
        begin
            tcp_next   = tcp_reg + {16'd0, plan_reg.rng_mask[0]};
            udp_next   = udp_reg + {16'd0, plan_reg.rng_mask[1]};
            sctp_next  = sctp_reg + {16'd0, plan_reg.rng_mask[2]};
            proto_next = proto_reg + {8'd0, plan_reg.rng_mask[3] && in_proto};
        end
    end

    // Memory port selection
    always_comb
    begin
        rd_addr = (state_reg == S_IDLE) ? entry_index[AW-1:0] : mark_ptr_reg[AW-1:0];
        wr_en   = (state_reg == S_CLEAR) || (state_reg == S_MARK_WR && !hit);
        wr_addr = (state_reg == S_CLEAR) ? clr_ptr_reg : mark_ptr_reg[AW-1:0];
        wr_data = (state_reg == S_CLEAR) ? 4'd0 : (rd_data_reg | plan_reg.rng_mask);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            port_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= port_mem[rd_addr];
    end

    // Results carry the counters as they stand after this cycle's update
    always_comb
    begin
        push           = 1'b0;
        push_data      = '0;
        push_data.tcp  = tcp_next;
        push_data.udp  = udp_next;
        push_data.sctp = sctp_next;
        push_data.proto = proto_next;
        unique case (state_reg)
            S_READ:
            begin
                push           = 1'b1;
                push_data.kind = KIND_READ;
                push_data.mask = cur_mask;
                push_data.bits = rd_oor_reg ? 4'd0 : rd_data_reg;
            end
            S_MARK_WR:
            begin
                push               = mark_done;
                push_data.kind     = KIND_RANGE;
                push_data.first    = plan_reg.rng_first;
                push_data.final_no = plan_reg.rng_last;
                push_data.mask     = plan_reg.rng_mask;
                push_data.dup      = rng_dup_reg || (hit && !dup_warned_reg);
            end
            S_EVENT:
            begin
                push           = 1'b1;
                push_data.kind = (plan_reg.ev_code == ERR_NONE) ? KIND_END : KIND_ERROR;
                push_data.mask = plan_reg.ev_mask;
                push_data.err  = plan_reg.ev_code;
            end
            default: push = 1'b0;
        endcase
    end

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:   if (clr_ptr_reg == LAST_ADDR) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (opcode == OP_PARSE)
                    begin
                        if (plan.rng_v)     state_next = S_MARK_RD;
                        else if (plan.ev_v) state_next = S_EVENT;
                    end
                    else if (opcode == OP_READ)  state_next = S_READ;
                    else if (opcode == OP_CLEAR) state_next = S_CLEAR;
                    else                         state_next = S_IDLE;
                end
            end
            S_READ:    state_next = S_IDLE;
            S_MARK_RD: state_next = S_MARK_WR;
            S_MARK_WR:
            begin
                if (!mark_done)       state_next = S_MARK_RD;
                else if (plan_reg.ev_v) state_next = S_EVENT;
                else                  state_next = S_IDLE;
            end
            S_EVENT:   state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_ptr_reg    <= '0;
            dup_warned_reg <= 1'b0;
            tcp_reg        <= 17'd0;
            udp_reg        <= 17'd0;
            sctp_reg       <= 17'd0;
            proto_reg      <= 9'd0;
            def_mask_reg   <= DEF_TYPE_MASK;
            allow_reg      <= DEF_ALLOW;
        end
        else
        begin
            state_reg <= state_next;
            tcp_reg   <= tcp_next;
            udp_reg   <= udp_next;
            sctp_reg  <= sctp_next;
            proto_reg <= proto_next;
            if (state_reg == S_CLEAR)
            begin
                clr_ptr_reg <= clr_ptr_reg + AW'(1);
            end
            if (state_reg == S_MARK_WR && hit)
            begin
                dup_warned_reg <= 1'b1;
            end
            // Clear: drop counters and the warning at once, sweep the table after
            if (accept && opcode == OP_CLEAR)
            begin
                clr_ptr_reg    <= '0;
                dup_warned_reg <= 1'b0;
                tcp_reg        <= 17'd0;
                udp_reg        <= 17'd0;
                sctp_reg       <= 17'd0;
                proto_reg      <= 9'd0;
            end
            if (mask_load)
            begin
                def_mask_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_ALLOW_CHANGE)
            begin
                allow_reg <= cfg_data[0];
            end
        end
    end

    // Request payload captured for the marking walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg     <= plan;
            mark_ptr_reg <= plan.rng_first;
            rng_dup_reg  <= 1'b0;
            rd_oor_reg   <= ({1'b0, entry_index} >= PORT_SZ);
        end
        else if (state_reg == S_MARK_WR)
        begin
            mark_ptr_reg <= mark_ptr_reg + 16'd1;
            if (hit && !dup_warned_reg)
            begin
                rng_dup_reg <= 1'b1;
            end
        end
    end

    // Output queue
    assign pop = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 2'd0;
            tail_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            if (push) tail_reg <= tail_reg + 2'd1;
            if (pop)  head_reg <= head_reg + 2'd1;
            count_reg <= count_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_q_reg[tail_reg] <= push_data;
        end
    end

    assign out_valid      = (count_reg != 3'd0);
    assign result_kind    = res_q_reg[head_reg].kind;
    assign range_first    = res_q_reg[head_reg].first;
    assign range_final    = res_q_reg[head_reg].final_no;
    assign type_mask      = res_q_reg[head_reg].mask;
    assign duplicate_seen = res_q_reg[head_reg].dup;
    assign error_code     = res_q_reg[head_reg].err;
    assign entry_bits     = res_q_reg[head_reg].bits;
    assign tcp_total      = res_q_reg[head_reg].tcp;
    assign udp_total      = res_q_reg[head_reg].udp;
    assign sctp_total     = res_q_reg[head_reg].sctp;
    assign proto_total    = res_q_reg[head_reg].proto;

    // Checks
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (state_reg == S_IDLE))
        else $error("request taken outside idle");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MARK_WR) |-> (mark_ptr_reg <= plan_reg.rng_last))
        else $error("marking walked past range end");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < 3'd4) || pop)
        else $error("result queue overflow");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

>>> sim/tb_port_list_spec_parser.sv
`timescale 1ns / 1ps
// Self-checking bench for the port-list parser: feeds spec text, reads and clears the table.
// Depends on psp_pkg and the port_list_spec_parser RTL.

module tb_port_list_spec_parser;
    import psp_pkg::*;

    localparam int PORTS  = 65536;
    localparam int PROTOS = 256;
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] first;
        logic [15:0] final_port;
        logic [3:0]  mask;
        logic        dup;
        logic [2:0]  err;
        logic [3:0]  bits;
        logic [16:0] tcp;
        logic [16:0] udp;
        logic [16:0] sctp;
        logic [8:0]  proto;
    } port_result_t;

    // Behavioural mirror of the parser and its table; queues what each request should yield.
    class spec_scoreboard;
        logic [3:0]   table_bits [PORTS];
        port_result_t expected_q [$];
        int           phase;
        logic [7:0]   held_letter;
        int           start_v, accum_v;
        logic [3:0]   cur_mask, def_mask;
        bit           allow_change, dup_warned, err_latched;
        int           tcp_n, udp_n, sctp_n, proto_n;
        int           failures;

        localparam int P_START = 0, P_SPACES = 1, P_PENDING = 2, P_NUM1 = 3,
                       P_AFTER1 = 4, P_DASH = 5, P_NUM2 = 6, P_TAIL = 7;

        function void reset_all();
            def_mask = 4'd1;
            allow_change = 1'b1;
            wipe();
            restart();
            failures = 0;
        endfunction

        function void wipe();
            foreach (table_bits[i]) table_bits[i] = 4'd0;
            tcp_n = 0; udp_n = 0; sctp_n = 0; proto_n = 0;
            dup_warned = 0;
        endfunction

        function void restart();
            phase = P_START; held_letter = 0; start_v = 0; accum_v = 0;
            cur_mask = def_mask; err_latched = 0;
        endfunction

        function void set_reg(logic idx, logic [3:0] val);
            if (idx == CFG_DEFAULT_MASK) begin
                def_mask = val;
                cur_mask = val;
            end else allow_change = val[0];
        endfunction

        function void push(logic [1:0] k, int f, int l, logic [3:0] m, bit d,
                           logic [2:0] e, logic [3:0] b);
            port_result_t r;
            r.kind = k; r.first = f[15:0]; r.final_port = l[15:0]; r.mask = m;
            r.dup = d; r.err = e; r.bits = b;
            r.tcp = tcp_n[16:0]; r.udp = udp_n[16:0]; r.sctp = sctp_n[16:0];
            r.proto = proto_n[8:0];
            expected_q.push_back(r);
        endfunction

        function void raise(logic [2:0] code);
            if (!err_latched) begin
                push(KIND_ERROR, 0, 0, cur_mask, 0, code, 0);
                err_latched = 1;
            end
        endfunction

        function int lim();
            return cur_mask[3] ? PROTOS - 1 : PORTS - 1;
        endfunction

        function bit space_ch(logic [7:0] c);
            return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
        endfunction

        function bit digit_ch(logic [7:0] c);
            return c >= 8'd48 && c <= 8'd57;
        endfunction

        function void grow(logic [7:0] c);
            int v;
            v = accum_v * 10 + (c - 48);
            accum_v = v > PORTS ? PORTS : v;
        endfunction

        function void mark(int f, int l);
            bit d;
            d = 0;
            for (int i = f; i <= l && i < PORTS; i++) begin
                if (table_bits[i] & cur_mask) begin
                    if (!dup_warned) begin
                        dup_warned = 1;
                        d = 1;
                    end
                end else begin
                    if (cur_mask[0]) tcp_n++;
                    if (cur_mask[1]) udp_n++;
                    if (cur_mask[2]) sctp_n++;
                    if (cur_mask[3] && i < PROTOS) proto_n++;
                    table_bits[i] |= cur_mask;
                end
            end
            push(KIND_RANGE, f, l, cur_mask, d, ERR_NONE, 0);
        endfunction

        function void open_token(logic [7:0] c);
            if (c == CH_DASH) begin
                start_v = cur_mask[3] ? 0 : 1;
                phase = P_DASH;
            end else if (digit_ch(c)) begin
                accum_v = c - 48;
                phase = P_NUM1;
            end else if (c == CH_LBRACK || c == CH_RBRACK) raise(ERR_BRACKET);
            else if ((c >= 8'd97 && c <= 8'd122) || c == CH_STAR || c == CH_QMARK)
                raise(ERR_NAME);
            else raise(ERR_SYNTAX);
        endfunction

        function void take_char(logic [7:0] c);
            bit again;
            again = 1;
            while (again) begin
                again = 0;
                case (phase)
                    P_START, P_SPACES: begin
                        if (space_ch(c)) phase = P_SPACES;
                        else if (allow_change) begin
                            held_letter = c;
                            phase = P_PENDING;
                        end else open_token(c);
                    end
                    P_NUM1: begin
                        if (digit_ch(c)) grow(c);
                        else if (accum_v > lim()) raise(ERR_RANGE);
                        else begin
                            start_v = accum_v;
                            phase = P_AFTER1;
                            again = 1;
                        end
                    end
                    P_AFTER1: begin
                        if (space_ch(c)) ;
                        else if (c == CH_DASH) phase = P_DASH;
                        else if (c == CH_COMMA) begin
                            mark(start_v, start_v);
                            phase = P_START;
                        end else if (c == CH_RBRACK) begin
                            mark(start_v, start_v);
                            raise(ERR_BRACKET);
                        end else raise(ERR_SYNTAX);
                    end
                    P_DASH: begin
                        if (digit_ch(c)) begin
                            accum_v = c - 48;
                            phase = P_NUM2;
                        end else if (c == CH_COMMA) begin
                            mark(start_v, lim());
                            phase = P_START;
                        end else if (c == CH_RBRACK) begin
                            mark(start_v, lim());
                            raise(ERR_BRACKET);
                        end else raise(ERR_SYNTAX);
                    end
                    P_NUM2: begin
                        if (digit_ch(c)) grow(c);
                        else if (accum_v > lim()) raise(ERR_RANGE);
                        else if (accum_v < start_v) raise(ERR_BACKWARDS);
                        else begin
                            mark(start_v, accum_v);
                            phase = P_TAIL;
                            again = 1;
                        end
                    end
                    default: begin
                        if (space_ch(c)) ;
                        else if (c == CH_COMMA) phase = P_START;
                        else raise(c == CH_RBRACK ? ERR_BRACKET : ERR_SYNTAX);
                    end
                endcase
            end
        endfunction

        function void close_spec();
            case (phase)
                P_SPACES: raise(ERR_SYNTAX);
                P_NUM1: if (accum_v > lim()) raise(ERR_RANGE);
                        else mark(accum_v, accum_v);
                P_AFTER1: mark(start_v, start_v);
                P_DASH: mark(start_v, lim());
                P_NUM2: begin
                    if (accum_v > lim()) raise(ERR_RANGE);
                    else if (accum_v < start_v) raise(ERR_BACKWARDS);
                    else mark(start_v, accum_v);
                end
                default: ;
            endcase
        endfunction

        // Note an accepted request and queue the results it should give.
        function void note_request(logic [1:0] op, logic [7:0] c, bit last,
                                   logic [15:0] idx);
            logic [7:0] p;
            if (op == OP_READ) begin
                push(KIND_READ, 0, 0, cur_mask, 0, ERR_NONE, table_bits[idx]);
                return;
            end
            if (op == OP_CLEAR) begin
                wipe();
                return;
            end
            if (op != OP_PARSE) return;
            if (err_latched) begin
                if (last) begin
                    push(KIND_END, 0, 0, cur_mask, 0, ERR_NONE, 0);
                    restart();
                end
                return;
            end
            if (phase == P_PENDING) begin
                p = held_letter;
                phase = P_START;
                if (c == CH_COLON) begin
                    if (p == CH_T) cur_mask = 4'd1;
                    else if (p == CH_U) cur_mask = 4'd2;
                    else if (p == CH_S) cur_mask = 4'd4;
                    else if (p == CH_P) cur_mask = 4'd8;
                    else raise(ERR_PREFIX);
                end else begin
                    open_token(p);
                    if (!err_latched) take_char(c);
                end
            end else take_char(c);
            if (last) begin
                if (!err_latched) begin
                    if (phase == P_PENDING) begin
                        phase = P_START;
                        open_token(held_letter);
                    end
                    if (!err_latched) close_spec();
                    if (!err_latched) push(KIND_END, 0, 0, cur_mask, 0, ERR_NONE, 0);
                end
                restart();
            end
        endfunction

        // Compare one result from the block against the oldest expectation.
        function void check_result(port_result_t got);
            port_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result kind=%0d", got.kind);
                failures++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.kind !== exp_r.kind) begin
                $error("result_kind exp %0d got %0d", exp_r.kind, got.kind); failures++;
            end
            if (got.first !== exp_r.first) begin
                $error("range_first exp %0d got %0d", exp_r.first, got.first); failures++;
            end
            if (got.final_port !== exp_r.final_port) begin
                $error("range_final exp %0d got %0d", exp_r.final_port, got.final_port);
                failures++;
            end
            if (got.mask !== exp_r.mask) begin
                $error("type_mask exp %0d got %0d", exp_r.mask, got.mask); failures++;
            end
            if (got.dup !== exp_r.dup) begin
                $error("duplicate_seen exp %0d got %0d", exp_r.dup, got.dup); failures++;
            end
            if (got.err !== exp_r.err) begin
                $error("error_code exp %0d got %0d", exp_r.err, got.err); failures++;
            end
            if (got.bits !== exp_r.bits) begin
                $error("entry_bits exp %0d got %0d", exp_r.bits, got.bits); failures++;
            end
            if (got.tcp !== exp_r.tcp) begin
                $error("tcp_total exp %0d got %0d", exp_r.tcp, got.tcp); failures++;
            end
            if (got.udp !== exp_r.udp) begin
                $error("udp_total exp %0d got %0d", exp_r.udp, got.udp); failures++;
            end
            if (got.sctp !== exp_r.sctp) begin
                $error("sctp_total exp %0d got %0d", exp_r.sctp, got.sctp); failures++;
            end
            if (got.proto !== exp_r.proto) begin
                $error("proto_total exp %0d got %0d", exp_r.proto, got.proto); failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  opcode = OP_PARSE;
    logic [7:0]  char_code = 8'd0;
    logic        is_last = 1'b0;
    logic [15:0] entry_index = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [1:0]  result_kind;
    logic [15:0] range_first, range_final;
    logic [3:0]  type_mask;
    logic        duplicate_seen;
    logic [2:0]  error_code;
    logic [3:0]  entry_bits;
    logic [16:0] tcp_total, udp_total, sctp_total;
    logic [8:0]  proto_total;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = CFG_DEFAULT_MASK;
    logic [3:0]  cfg_data = 4'd0;

    spec_scoreboard board;
    longint cycle_count = 0;
    bit     hold_results = 1'b0;  // long receiver hold-off while set
    int     hold_cycles = 0;

    port_list_spec_parser uut (.*);

    always #5 clk = ~clk;

    // Timeout: a generous bound on the slowest legal run, including clearing passes.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("port_list_spec_parser regression: fail");
            $finish;
        end
    end

    // Receiver: random stall per result, with a long hold-off on request.
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        forever begin
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (hold_results) begin
                wait_n = hold_cycles;
                hold_results = 1'b0;
            end
            if (wait_n > 0) begin
                out_stall <= 1'b1;
                repeat (wait_n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            board.check_result({result_kind, range_first, range_final, type_mask,
                                duplicate_seen, error_code, entry_bits, tcp_total,
                                udp_total, sctp_total, proto_total});
        end
    end

    bit no_gaps = 1'b0;

    // Send one request, after a random gap, and note it once accepted.
    // Valid stays high after acceptance; a gap or drain drops it.
    task automatic send_request(logic [1:0] op, logic [7:0] c, bit last, logic [15:0] idx);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op; char_code <= c; is_last <= last; entry_index <= idx;
        do @(posedge clk); while (in_stall);
        board.note_request(op, c, last, idx);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_request(OP_PARSE, s[i], i == s.len() - 1, 16'd0);
    endtask

    // Drop valid and hold until every expected result has come, plus a short settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        board.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random spec with short ranges, mostly well-formed; low ports mostly to keep marking quick.
    function automatic string random_spec();
        string s, pre;
        int n, a, b;
        s = "";
        n = $urandom_range(1, 3);
        for (int t = 0; t < n; t++) begin
            case ($urandom_range(0, 7))
                0: pre = "T:";
                1: pre = "U:";
                2: pre = "S:";
                3: pre = "P:";
                default: pre = "";
            endcase
            a = $urandom_range(0, 300);
            b = a + $urandom_range(0, 12);
            if ($urandom_range(0, 40) == 0) a = 65530 + $urandom_range(0, 9);
            case ($urandom_range(0, 5))
                0: s = {s, pre, $sformatf("%0d", a)};
                1: s = {s, pre, $sformatf("%0d-%0d", a, b)};
                2: s = {s, pre, $sformatf("%0d - %0d", b, a)};
                3: s = {s, pre, $sformatf("-%0d", $urandom_range(0, 6))};
                4: s = {s, pre, $sformatf(" %0d ", a)};
                default: s = {s, pre, $sformatf("%0d-%0d", a, b)};
            endcase
            if (t != n - 1) s = {s, ","};
        end
        if ($urandom_range(0, 9) == 0) s = {s, ","};
        return s;
    endfunction

    initial
    begin
        int sent;
        string s;
        board = new();
        board.reset_all();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: prefixes, open ends, brackets, names, limits and each error.
        write_reg(CFG_ALLOW_CHANGE, 4'd1);
        write_reg(CFG_DEFAULT_MASK, 4'd1);
        send_text("-3,T:5-6,U:65535,P:250-");
        send_text("65536");
        send_text("7 ,");
        send_text("X:1");
        send_text("9-4");
        send_text("[");
        send_text("8]");
        send_text("a1");
        send_text("5,");
        send_text("P:-0");
        send_text("-0");
        send_text("1 2");
        send_text("99999999");
        send_request(OP_READ, 8'd0, 1'b0, 16'd5);
        send_request(OP_READ, 8'd0, 1'b0, 16'hFFFF);
        send_request(2'd3, 8'hFF, 1'b1, 16'hFFFF);
        drain();

        // Extremes of the config registers.
        write_reg(CFG_DEFAULT_MASK, 4'd15);
        write_reg(CFG_ALLOW_CHANGE, 4'd0);
        send_text("0-3,T:1");
        send_text("?");
        drain();
        write_reg(CFG_DEFAULT_MASK, 4'd0);
        send_text("12");
        drain();
        write_reg(CFG_DEFAULT_MASK, 4'd1);
        write_reg(CFG_ALLOW_CHANGE, 4'd1);

        // Long receiver hold-off while requests keep coming, so input backs up.
        hold_cycles = 400;
        hold_results = 1'b1;
        no_gaps = 1'b1;
        for (int i = 0; i < 20; i++) send_request(OP_READ, 8'd0, 1'b0, 16'($urandom()));
        no_gaps = 1'b0;
        drain();

        sent = 0;
        while (sent < 1350) begin
            case ($urandom_range(0, 19))
                0: begin
                    send_request(OP_PARSE, 8'($urandom()), 1'($urandom_range(0, 1)),
                                 16'($urandom()));
                    sent++;
                end
                1, 2: begin
                    send_request(OP_READ, 8'($urandom()), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 1) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 320)));
                    sent++;
                end
                3: if ($urandom_range(0, 30) == 0) begin
                    send_request(OP_CLEAR, 8'($urandom()), 1'($urandom_range(0, 1)),
                                 16'($urandom()));
                    sent++;
                end
                4: begin
                    // Possibly broken spec: a random spec with one character replaced, terminated.
                    s = random_spec();
                    s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(32, 126));
                    send_text(s);
                    sent += s.len();
                end
                5: if ($urandom_range(0, 15) == 0) begin
                    drain();
                    write_reg(CFG_DEFAULT_MASK, 4'($urandom_range(0, 15)));
                    write_reg(CFG_ALLOW_CHANGE, 4'($urandom_range(0, 1)));
                end
                default: begin
                    s = random_spec();
                    send_text(s);
                    sent += s.len();
                end
            endcase
        end

        drain();
        if (board.failures == 0 && board.expected_q.size() == 0)
            $display("port_list_spec_parser regression: pass");
        else
            $display("port_list_spec_parser regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/psp_pkg.sv
src/psp_parser.sv
src/port_list_spec_parser.sv
sim/tb_port_list_spec_parser.sv
